// ===== src/vsam_pkg.sv =====
package vsam_pkg;

	// command codes carried on cmd
	localparam logic [2:0] CMD_MARK_DEF = 3'd0;
	localparam logic [2:0] CMD_MARK_VAL = 3'd1;
	localparam logic [2:0] CMD_CLEAR    = 3'd2;
	localparam logic [2:0] CMD_FIND_DEF = 3'd3;
	localparam logic [2:0] CMD_FIND_VAL = 3'd4;
	localparam logic [2:0] CMD_READ     = 3'd5;

	localparam int          CMD_W    = 3;
	localparam int          IDX_W    = 7;
	localparam int          VAL_W    = 32;
	localparam int          CNT_OUT_W = 8;
	localparam logic [31:0] TAG_DEF  = 32'hFFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the input word
		logic read;   // issue the value RAM read
		logic exec;   // apply the command and load the output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free; // output register can take a new word this cycle
	} ctl_sts_t;

endpackage

// ===== src/vsam_ram.sv =====
module vsam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/vsam_ctrl.sv =====
module vsam_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vsam_pkg::ctl_sts_t  sts,
	output vsam_pkg::ctl_cmd_t  cmd
);

	import vsam_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.read = (state_q == ST_READ);
	assign cmd.exec = (state_q == ST_EXEC) && sts.out_free;

endmodule

// ===== src/vsam_dpath.sv =====
module vsam_dpath #(
	parameter int ENTRIES = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vsam_pkg::ctl_cmd_t                  cmd,
	output vsam_pkg::ctl_sts_t                  sts,
	input  logic [vsam_pkg::CMD_W-1:0]          in_cmd,
	input  logic [vsam_pkg::IDX_W-1:0]          in_index,
	input  logic [vsam_pkg::VAL_W-1:0]          in_tag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vsam_pkg::IDX_W-1:0]          out_slot,
	output logic                                out_found,
	output logic [vsam_pkg::VAL_W-1:0]          out_value,
	output logic                                out_in_use,
	output logic [vsam_pkg::CNT_OUT_W-1:0]      out_free_count,
	output logic                                out_error
);

	import vsam_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int XW = (AW > IDX_W) ? AW : IDX_W;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W + 1;
	localparam logic [XW:0]   ENTRIES_X = (XW + 1)'(ENTRIES);
	localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
	localparam logic [SW-1:0] SAT_MAX   = SW'((1 << CNT_OUT_W) - 1);

	// captured command word
	logic [CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] tag_q;

	// occupancy, free count and registered lowest free slot
	logic [ENTRIES-1:0] occ_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      free_addr_q;
	logic               any_free_q;

	// output register
	logic               out_valid_q;
	logic [IDX_W-1:0]   slot_q;
	logic               found_q;
	logic [VAL_W-1:0]   value_q;
	logic               used_q;
	logic [CNT_OUT_W-1:0] fcnt_q;
	logic               error_q;

	logic [AW-1:0]   enc_addr;
	logic            enc_any;
	logic [XW-1:0]   idx_ext;
	logic [XW-1:0]   free_ext;
	logic            idx_ok;
	logic            is_find;
	logic            is_mark;
	logic            zero_err;
	logic            tgt_ok;
	logic [AW-1:0]   tgt_addr;
	logic [VAL_W-1:0] wval;
	logic            was;
	logic            do_write;
	logic            do_clear;
	logic [CW-1:0]   cnt_d;
	logic [SW-1:0]   cnt_ext;
	logic [VAL_W-1:0] rdata;
	logic [VAL_W-1:0] res_value;
	logic            res_used;
	logic [IDX_W-1:0] res_slot;

	// lowest clear bit of the occupancy vector
	always_comb begin
		enc_addr = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				enc_addr = AW'(i);
			end
		end
		enc_any = ~&occ_q;
	end

	assign idx_ext  = XW'(idx_q);
	assign free_ext = XW'(free_addr_q);
	assign idx_ok   = ({1'b0, idx_ext} < ENTRIES_X);
	assign is_find  = (cmd_q == CMD_FIND_DEF) || (cmd_q == CMD_FIND_VAL);
	assign is_mark  = (cmd_q == CMD_MARK_DEF) || (cmd_q == CMD_MARK_VAL);
	assign zero_err = ((cmd_q == CMD_MARK_VAL) || (cmd_q == CMD_FIND_VAL)) && (tag_q == '0);
	assign wval     = ((cmd_q == CMD_MARK_DEF) || (cmd_q == CMD_FIND_DEF)) ? TAG_DEF : tag_q;
	assign tgt_ok   = is_find ? any_free_q : idx_ok;
	assign tgt_addr = is_find ? free_addr_q : idx_ext[AW-1:0];
	assign was      = tgt_ok && occ_q[tgt_addr];
	assign do_write = tgt_ok && !zero_err && (is_mark || is_find);
	assign do_clear = tgt_ok && (cmd_q == CMD_CLEAR);

	always_comb begin
		cnt_d = cnt_q;
		if (do_write && !was) begin
			cnt_d = cnt_q - 1'b1;
		end else if (do_clear && was) begin
			cnt_d = cnt_q + 1'b1;
		end
	end

	assign cnt_ext = SW'(cnt_d);

	// a slot not marked in use reads as zero whatever the RAM holds
	always_comb begin
		if (do_write) begin
			res_value = wval;
			res_used  = 1'b1;
		end else if (do_clear || !was) begin
			res_value = '0;
			res_used  = 1'b0;
		end else begin
			res_value = rdata;
			res_used  = 1'b1;
		end
	end

	assign res_slot = is_find ? (any_free_q ? free_ext[IDX_W-1:0] : '0) : idx_q;

	vsam_ram #(
		.WIDTH (VAL_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec && do_write),
		.waddr (tgt_addr),
		.wdata (wval),
		.re    (cmd.read),
		.raddr (tgt_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			idx_q <= in_index;
			tag_q <= in_tag;
		end
		if (cmd.exec) begin
			slot_q  <= res_slot;
			found_q <= is_find ? any_free_q : 1'b1;
			value_q <= res_value;
			used_q  <= res_used;
			fcnt_q  <= (cnt_ext > SAT_MAX) ? SAT_MAX[CNT_OUT_W-1:0] : cnt_ext[CNT_OUT_W-1:0];
			error_q <= zero_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			cnt_q       <= ENTRIES_C;
			free_addr_q <= '0;
			any_free_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			free_addr_q <= enc_addr;
			any_free_q  <= enc_any;
			if (cmd.exec) begin
				cnt_q <= cnt_d;
				if (do_write) begin
					occ_q[tgt_addr] <= 1'b1;
				end else if (do_clear) begin
					occ_q[tgt_addr] <= 1'b0;
				end
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free    = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_slot        = slot_q;
	assign out_found       = found_q;
	assign out_value       = value_q;
	assign out_in_use      = used_q;
	assign out_free_count  = fcnt_q;
	assign out_error       = error_q;

endmodule

// ===== src/valued_slot_allocation_map_unit.sv =====
// Valued slot allocation map: a first-fit table of ENTRIES slots of signed
// 32-bit words, zero meaning free.
// Input channel (in_valid / in_stall) carries one command word: cmd,
// slot_index and tag_value. Commands mark, clear, read a slot or find the
// lowest free slot and tag it.
// Output channel (out_valid / out_stall) carries one result word per command:
// slot_out, found, slot_value, in_use, free_count and error.
// Each word passes capture, value RAM read and execute in turn; the input
// stalls until it is executed, so a new word is not taken before the last
// is done. The registered read of the value RAM sets the middle step. The
// lowest free slot comes from a priority encoder over the occupancy flops,
// registered every cycle, so a find costs no more than a read.
// The output register frees the execute step: a result may wait under
// out_stall while the next word is captured and read; execution then holds
// until the waiting word is taken.
// Reset clears the occupancy flops and sets the free count to ENTRIES at
// once; no clearing pass, as a slot not marked in use reads as zero.
module valued_slot_allocation_map_unit #(
	parameter int ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          cmd,
	input  logic [6:0]          slot_index,
	input  logic signed [31:0]  tag_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [6:0]          slot_out,
	output logic                found,
	output logic signed [31:0]  slot_value,
	output logic                in_use,
	output logic [7:0]          free_count,
	output logic                error
);

	import vsam_pkg::*;

	localparam logic [7:0] FC_RESET = (ENTRIES > 255) ? 8'd255 : 8'(ENTRIES);

	ctl_cmd_t    ctl_cmd;
	ctl_sts_t    ctl_sts;
	logic [31:0] value_u;
	logic [7:0]  prev_fc_q;

	// sequence each word through capture, read and execute
	vsam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	// hold the table, the counts and the output register
	vsam_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (ctl_sts),
		.in_cmd         (cmd),
		.in_index       (slot_index),
		.in_tag         (tag_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_slot       (slot_out),
		.out_found      (found),
		.out_value      (value_u),
		.out_in_use     (in_use),
		.out_free_count (free_count),
		.out_error      (error)
	);

	assign slot_value = value_u;

	// free count carried by the last word taken on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_fc_q <= FC_RESET;
		end else if (out_valid && !out_stall) begin
			prev_fc_q <= free_count;
		end
	end

	// a captured word blocks the input for the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in flight");

	// in use exactly when the reported word is nonzero
	a_use_matches_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_use == (slot_value != 32'sd0)))
		else $error("in_use disagrees with slot_value");

	// a failed find reports slot zero, empty
	a_not_found_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (slot_out == 7'd0 && !in_use && free_count == 8'd0))
		else $error("not-found result carries a slot");

	// a command rejected for a zero tag leaves the free count as the previous word left it
	a_error_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (free_count == prev_fc_q))
		else $error("rejected mark changed the free count");

endmodule
